### src/ttcm_pkg.sv
// Shared constants and types for the touch tap coordinate mapper.
package ttcm_pkg;

  // Screen geometry.
  localparam int SCREEN_W   = 800;
  localparam int SCREEN_H   = 480;
  localparam int SCREEN_MAX = 4096;

  // Scale factor (screen size minus one) width and the axis product width.
  localparam int RAW_W   = 32;
  localparam int SCALE_W = $clog2(SCREEN_MAX);
  localparam int PROD_W  = RAW_W + SCALE_W;

  typedef logic [SCALE_W-1:0]      scale_t;
  typedef logic signed [RAW_W-1:0] raw_t;

  localparam scale_t SCALE_X = SCALE_W'(SCREEN_W - 1);
  localparam scale_t SCALE_Y = SCALE_W'(SCREEN_H - 1);

  // Field widths.
  localparam int TYPE_W   = 16;
  localparam int CODE_W   = 16;
  localparam int TIME_W   = 32;
  localparam int MS_CFG_W = 16;
  localparam int TAP_X_W  = 10;
  localparam int TAP_Y_W  = 9;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_FLD_W  = TAP_X_W + TAP_Y_W + TIME_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // Event codes.
  localparam logic [TYPE_W-1:0] EVT_KEY   = 16'd1;
  localparam logic [TYPE_W-1:0] EVT_ABS   = 16'd3;
  localparam logic [CODE_W-1:0] AXIS_X    = 16'd0;
  localparam logic [CODE_W-1:0] AXIS_Y    = 16'd1;
  localparam logic [CODE_W-1:0] KEY_TOUCH = 16'd330;
  localparam raw_t              KEY_PRESS   = 32'sd1;
  localparam raw_t              KEY_RELEASE = 32'sd0;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_X_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_X_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_Y_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_Y_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_MAX    = 3'd5;

endpackage

### src/ttcm_axis.sv
// One axis of the mapper: serial multiply by the scale, then restoring divide by the range.
module ttcm_axis (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ttcm_pkg::raw_t  raw,
  input  ttcm_pkg::raw_t  lo,
  input  ttcm_pkg::raw_t  hi,
  input  ttcm_pkg::scale_t scale,
  output logic            busy,
  output ttcm_pkg::scale_t qc
);

  localparam int RAW_W   = ttcm_pkg::RAW_W;
  localparam int SCALE_W = ttcm_pkg::SCALE_W;
  localparam int PROD_W  = ttcm_pkg::PROD_W;
  localparam int CNT_W   = $clog2(PROD_W);
  localparam int SIDX_W  = $clog2(SCALE_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RAW_W-1:0]  mag_r, mag_nxt;
  logic [RAW_W-1:0]  range_r, range_nxt;
  logic              neg_r, neg_nxt;
  logic [PROD_W-1:0] p_r, p_nxt;
  logic [RAW_W-1:0]  rem_r, rem_nxt;
  logic [SCALE_W-1:0] q_r, q_nxt;
  logic              ovf_r, ovf_nxt;

  logic signed [RAW_W:0] off;
  logic signed [RAW_W:0] rng;
  logic [RAW_W:0]        trial;
  logic [RAW_W+1:0]      diff;
  logic                  ge;

  assign off   = {raw[RAW_W-1], raw} - {lo[RAW_W-1], lo};
  assign rng   = {hi[RAW_W-1], hi} - {lo[RAW_W-1], lo};
  assign trial = {rem_r, p_r[PROD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, range_r};
  assign ge    = ~diff[RAW_W+1];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    range_nxt = range_r;
    neg_nxt   = neg_r;
    p_nxt     = p_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          neg_nxt   = off[RAW_W];
          mag_nxt   = off[RAW_W-1:0];
          // a range of zero or less divides by one
          range_nxt = (rng <= 0) ? RAW_W'(1) : rng[RAW_W-1:0];
          p_nxt     = '0;
          rem_nxt   = '0;
          q_nxt     = '0;
          ovf_nxt   = 1'b0;
          cnt_nxt   = CNT_W'(SCALE_W - 1);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // MSB-first shift-add over the scale bits
        p_nxt = {p_r[PROD_W-2:0], 1'b0} +
                (scale[cnt_r[SIDX_W-1:0]] ? {{SCALE_W{1'b0}}, mag_r} : '0);
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(PROD_W - 1);
          state_nxt = ST_DIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DIV: begin
        p_nxt   = {p_r[PROD_W-2:0], 1'b0};
        rem_nxt = ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
        // only whether the quotient exceeds the scale matters above SCALE_W bits
        ovf_nxt = ovf_r | q_r[SCALE_W-1];
        q_nxt   = {q_r[SCALE_W-2:0], ge};
        if (cnt_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    range_r <= range_nxt;
    neg_r   <= neg_nxt;
    p_r     <= p_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign busy = (state_r != ST_IDLE);

  // negative offset gives a quotient of zero or below, so the clamp lands on 0
  always_comb begin
    if (neg_r) begin
      qc = '0;
    end else if (ovf_r || (q_r > scale)) begin
      qc = scale;
    end else begin
      qc = q_r;
    end
  end

endmodule

### src/touch_tap_coordinate_mapper_unit.sv
// Top level of the touch tap coordinate mapper: event decode, press timing and tap output.
//
// Takes one input event per transaction. Axis and press events, and releases that do not make
// a tap, are taken without leaving the idle state. A release that makes a tap starts both
// axis units, which run side by side: a bit-serial multiply by the screen size minus one and
// a restoring divide by the calibrated range, one quotient bit per cycle. The input accepts
// again once the tap is loaded into the output register, which waits until both axis units
// are done and the output register is free. A tap still waiting on the output does not stop
// new events from being accepted. Tap Y is flipped so the origin is at the bottom, and both
// axes are clamped to the screen.
module touch_tap_coordinate_mapper_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // event_type[15:0], event_code[31:16], event_value[63:32], now_ms[95:64]
  input  logic [ttcm_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tap_x[9:0], tap_y[18:10], tap_start_ms[50:19], zero pad above
  output logic [ttcm_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [ttcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttcm_pkg::RAW_W-1:0]          cfg_wdata
);

  localparam int TIME_W   = ttcm_pkg::TIME_W;
  localparam int MS_CFG_W = ttcm_pkg::MS_CFG_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  // Configuration.
  ttcm_pkg::raw_t        x_low_r, x_high_r, y_low_r, y_high_r;
  logic [MS_CFG_W-1:0]   tap_min_r, tap_max_r;

  // Tracking state.
  logic                  state_r, state_nxt;
  ttcm_pkg::raw_t        last_x_r, last_x_nxt;
  ttcm_pkg::raw_t        last_y_r, last_y_nxt;
  logic                  touch_down_r, touch_down_nxt;
  logic [TIME_W-1:0]     press_begin_r, press_begin_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [ttcm_pkg::TAP_X_W-1:0] tap_x_r;
  logic [ttcm_pkg::TAP_Y_W-1:0] tap_y_r;
  logic [TIME_W-1:0]     tap_start_r;

  logic [ttcm_pkg::TYPE_W-1:0] ev_type;
  logic [ttcm_pkg::CODE_W-1:0] ev_code;
  ttcm_pkg::raw_t        ev_value;
  logic [TIME_W-1:0]     ev_now;
  logic [TIME_W-1:0]     dur;
  logic                  in_acc;
  logic                  tap_hit;
  logic                  load_out;

  logic                  x_busy, y_busy;
  ttcm_pkg::scale_t      qc_x, qc_y;
  ttcm_pkg::scale_t      y_flip;

  assign ev_type  = in_tdata[15:0];
  assign ev_code  = in_tdata[31:16];
  assign ev_value = in_tdata[63:32];
  assign ev_now   = in_tdata[95:64];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign dur       = ev_now - press_begin_r;

  always_comb begin
    state_nxt       = state_r;
    last_x_nxt      = last_x_r;
    last_y_nxt      = last_y_r;
    touch_down_nxt  = touch_down_r;
    press_begin_nxt = press_begin_r;
    tap_hit         = 1'b0;
    load_out        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (ev_type == ttcm_pkg::EVT_ABS) begin
            if (ev_code == ttcm_pkg::AXIS_X) begin
              last_x_nxt = ev_value;
            end else if (ev_code == ttcm_pkg::AXIS_Y) begin
              last_y_nxt = ev_value;
            end
          end else if (ev_type == ttcm_pkg::EVT_KEY && ev_code == ttcm_pkg::KEY_TOUCH) begin
            if (ev_value == ttcm_pkg::KEY_PRESS) begin
              touch_down_nxt  = 1'b1;
              press_begin_nxt = ev_now;
            end else if (ev_value == ttcm_pkg::KEY_RELEASE) begin
              touch_down_nxt = 1'b0;
              if (touch_down_r && (dur >= TIME_W'(tap_min_r)) &&
                  (dur < TIME_W'(tap_max_r))) begin
                tap_hit   = 1'b1;
                state_nxt = ST_BUSY;
              end
            end
          end
        end
      end
      ST_BUSY: begin
        if (!x_busy && !y_busy && (!out_valid_r || out_tready)) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      last_x_r      <= '0;
      last_y_r      <= '0;
      touch_down_r  <= 1'b0;
      press_begin_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      last_x_r      <= last_x_nxt;
      last_y_r      <= last_y_nxt;
      touch_down_r  <= touch_down_nxt;
      press_begin_r <= press_begin_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r   <= 32'sd0;
      x_high_r  <= 32'sd1023;
      y_low_r   <= 32'sd0;
      y_high_r  <= 32'sd1023;
      tap_min_r <= 16'd50;
      tap_max_r <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        ttcm_pkg::REG_RAW_X_LOW:  x_low_r   <= cfg_wdata;
        ttcm_pkg::REG_RAW_X_HIGH: x_high_r  <= cfg_wdata;
        ttcm_pkg::REG_RAW_Y_LOW:  y_low_r   <= cfg_wdata;
        ttcm_pkg::REG_RAW_Y_HIGH: y_high_r  <= cfg_wdata;
        ttcm_pkg::REG_TAP_MIN:    tap_min_r <= cfg_wdata[MS_CFG_W-1:0];
        ttcm_pkg::REG_TAP_MAX:    tap_max_r <= cfg_wdata[MS_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ttcm_axis u_axis_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tap_hit),
    .raw   (last_x_r),
    .lo    (x_low_r),
    .hi    (x_high_r),
    .scale (ttcm_pkg::SCALE_X),
    .busy  (x_busy),
    .qc    (qc_x)
  );

  ttcm_axis u_axis_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tap_hit),
    .raw   (last_y_r),
    .lo    (y_low_r),
    .hi    (y_high_r),
    .scale (ttcm_pkg::SCALE_Y),
    .busy  (y_busy),
    .qc    (qc_y)
  );

  // qc_y never exceeds the scale, so the flip stays in range
  assign y_flip = ttcm_pkg::SCALE_Y - qc_y;

  always_ff @(posedge clk) begin
    if (load_out) begin
      tap_x_r     <= qc_x[ttcm_pkg::TAP_X_W-1:0];
      tap_y_r     <= y_flip[ttcm_pkg::TAP_Y_W-1:0];
      tap_start_r <= press_begin_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ttcm_pkg::OUT_DATA_W - ttcm_pkg::OUT_FLD_W){1'b0}},
                       tap_start_r, tap_y_r, tap_x_r};

endmodule

### bench/testbench.sv
// Self-checking testbench for touch_tap_coordinate_mapper_unit: random event streams vs. a tap predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef ttcm_pkg::raw_t raw_t;

  localparam int SCREEN_W   = ttcm_pkg::SCREEN_W;
  localparam int SCREEN_H   = ttcm_pkg::SCREEN_H;
  localparam int RAW_W      = ttcm_pkg::RAW_W;
  localparam int TYPE_W     = ttcm_pkg::TYPE_W;
  localparam int CODE_W     = ttcm_pkg::CODE_W;
  localparam int TIME_W     = ttcm_pkg::TIME_W;
  localparam int MS_CFG_W   = ttcm_pkg::MS_CFG_W;
  localparam int TAP_X_W    = ttcm_pkg::TAP_X_W;
  localparam int TAP_Y_W    = ttcm_pkg::TAP_Y_W;
  localparam int IN_DATA_W  = ttcm_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = ttcm_pkg::OUT_DATA_W;
  localparam int CFG_IDX_W  = ttcm_pkg::CFG_IDX_W;

  localparam logic [TYPE_W-1:0] EVT_KEY   = ttcm_pkg::EVT_KEY;
  localparam logic [TYPE_W-1:0] EVT_ABS   = ttcm_pkg::EVT_ABS;
  localparam logic [CODE_W-1:0] AXIS_X    = ttcm_pkg::AXIS_X;
  localparam logic [CODE_W-1:0] AXIS_Y    = ttcm_pkg::AXIS_Y;
  localparam logic [CODE_W-1:0] KEY_TOUCH = ttcm_pkg::KEY_TOUCH;
  localparam raw_t              KEY_PRESS   = ttcm_pkg::KEY_PRESS;
  localparam raw_t              KEY_RELEASE = ttcm_pkg::KEY_RELEASE;

  localparam logic [CFG_IDX_W-1:0] REG_RAW_X_LOW  = ttcm_pkg::REG_RAW_X_LOW;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_X_HIGH = ttcm_pkg::REG_RAW_X_HIGH;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_Y_LOW  = ttcm_pkg::REG_RAW_Y_LOW;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_Y_HIGH = ttcm_pkg::REG_RAW_Y_HIGH;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_MIN    = ttcm_pkg::REG_TAP_MIN;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_MAX    = ttcm_pkg::REG_TAP_MAX;

  localparam int IDLE_GAP = 80;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

  typedef struct packed {
    logic [TAP_X_W-1:0] x;
    logic [TAP_Y_W-1:0] y;
    logic [TIME_W-1:0]  start_ms;
  } tap_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [RAW_W-1:0]       cfg_wdata = '0;

  touch_tap_coordinate_mapper_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Calibration copy and tracked touch state
  raw_t                cal_x_lo = 32'sd0;
  raw_t                cal_x_hi = 32'sd1023;
  raw_t                cal_y_lo = 32'sd0;
  raw_t                cal_y_hi = 32'sd1023;
  logic [MS_CFG_W-1:0] hold_min = 16'd50;
  logic [MS_CFG_W-1:0] hold_max = 16'd1000;
  raw_t                pos_x = '0;
  raw_t                pos_y = '0;
  logic                touching = 1'b0;
  logic [TIME_W-1:0]   touch_ms = '0;

  logic [IN_DATA_W-1:0] events_to_send[$];
  tap_t                 taps_due[$];
  int                   events_queued = 0;
  int                   events_taken = 0;
  int                   taps_checked = 0;
  int                   errors = 0;
  int                   settings_run = 0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  logic [TIME_W-1:0]    gen_ms = '0;

  function automatic longint map_axis(raw_t raw, raw_t lo, raw_t hi, longint size);
    longint span;
    longint offset;
    span = longint'(hi) - longint'(lo);
    offset = longint'(raw) - longint'(lo);
    if (span <= 0) span = 1;
    return offset * (size - 1) / span;
  endfunction

  function automatic longint clamp_axis(longint v, longint size);
    if (v < 0) v = 0;
    if (v >= size) v = size - 1;
    return v;
  endfunction

  // Updates the touch state for one accepted transaction and queues the tap it makes, if any.
  function automatic void track_event(input logic [IN_DATA_W-1:0] d);
    logic [TYPE_W-1:0] ev_kind;
    logic [CODE_W-1:0] ev_code;
    raw_t              ev_value;
    logic [TIME_W-1:0] ev_ms;
    logic [TIME_W-1:0] held;
    longint            sx;
    longint            sy;
    tap_t              tap;
    ev_kind  = d[TYPE_W-1:0];
    ev_code  = d[TYPE_W +: CODE_W];
    ev_value = d[TYPE_W+CODE_W +: RAW_W];
    ev_ms    = d[TYPE_W+CODE_W+RAW_W +: TIME_W];
    if (ev_kind == EVT_ABS) begin
      if (ev_code == AXIS_X) pos_x = ev_value;
      else if (ev_code == AXIS_Y) pos_y = ev_value;
    end else if (ev_kind == EVT_KEY && ev_code == KEY_TOUCH) begin
      if (ev_value == KEY_PRESS) begin
        touching = 1'b1;
        touch_ms = ev_ms;
      end else if (ev_value == KEY_RELEASE) begin
        held = ev_ms - touch_ms;
        if (touching && held >= {16'd0, hold_min} && held < {16'd0, hold_max}) begin
          sx = clamp_axis(map_axis(pos_x, cal_x_lo, cal_x_hi, SCREEN_W), SCREEN_W);
          sy = (SCREEN_H - 1) - map_axis(pos_y, cal_y_lo, cal_y_hi, SCREEN_H);
          sy = clamp_axis(sy, SCREEN_H);
          tap.x = sx[TAP_X_W-1:0];
          tap.y = sy[TAP_Y_W-1:0];
          tap.start_ms = touch_ms;
          taps_due.push_back(tap);
        end
        touching = 1'b0;
      end
    end
  endfunction

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_event(in_tdata);
        events_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (events_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= events_to_send.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Tap monitor
  always @(posedge clk) begin
    tap_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (taps_due.size() == 0) begin
          $display("%0t: unexpected tap, expected none, got x=%0d y=%0d start=%0d", $time,
                   out_tdata[TAP_X_W-1:0], out_tdata[TAP_X_W +: TAP_Y_W],
                   out_tdata[TAP_X_W+TAP_Y_W +: TIME_W]);
          errors++;
        end else begin
          want = taps_due.pop_front();
          taps_checked++;
          if (out_tdata[TAP_X_W-1:0] !== want.x) begin
            $display("%0t: tap_x expected %0d got %0d", $time, want.x, out_tdata[TAP_X_W-1:0]);
            errors++;
          end
          if (out_tdata[TAP_X_W +: TAP_Y_W] !== want.y) begin
            $display("%0t: tap_y expected %0d got %0d", $time, want.y,
                     out_tdata[TAP_X_W +: TAP_Y_W]);
            errors++;
          end
          if (out_tdata[TAP_X_W+TAP_Y_W +: TIME_W] !== want.start_ms) begin
            $display("%0t: tap_start_ms expected %0d got %0d", $time, want.start_ms,
                     out_tdata[TAP_X_W+TAP_Y_W +: TIME_W]);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic post_event(input logic [TYPE_W-1:0] kind, input logic [CODE_W-1:0] code,
                            input raw_t value, input logic [TIME_W-1:0] stamp);
    events_to_send.push_back({stamp, value, code, kind});
    events_queued++;
  endtask

  function automatic logic [TIME_W-1:0] step_ms();
    gen_ms = gen_ms + $urandom_range(1, 200);
    return gen_ms;
  endfunction

  // Raw axis value, mostly inside the calibrated span, with the extremes mixed in.
  function automatic raw_t pick_raw(raw_t lo, raw_t hi);
    longint     span;
    logic [63:0] offset;
    raw_t       v;
    span = longint'(hi) - longint'(lo);
    case ($urandom_range(7))
      0: v = lo;
      1: v = hi;
      2: v = $urandom;
      3: v = 32'h8000_0000;
      4: v = 32'h7fff_ffff;
      default: begin
        if (span > 0) begin
          offset = {32'd0, $urandom} % span;
          v = lo + offset[31:0];
        end else begin
          v = lo + $urandom_range(0, 4000) - 2000;
        end
      end
    endcase
    return v;
  endfunction

  // Press length aimed at the edges of the accepted window.
  function automatic logic [TIME_W-1:0] pick_hold();
    logic [TIME_W-1:0] mn;
    logic [TIME_W-1:0] mx;
    logic [TIME_W-1:0] h;
    mn = {16'd0, hold_min};
    mx = {16'd0, hold_max};
    case ($urandom_range(9))
      0: h = mn;
      1: h = mn - 1;
      2: h = mx - 1;
      3: h = mx;
      4: h = $urandom;
      default: begin
        if (mx > mn) h = mn + $urandom_range(0, mx - mn - 1);
        else h = $urandom_range(0, mn + 10);
      end
    endcase
    return h;
  endfunction

  task automatic add_tap_sequence();
    logic [TIME_W-1:0] press_at;
    if ($urandom_range(9) < 8) post_event(EVT_ABS, AXIS_X, pick_raw(cal_x_lo, cal_x_hi), step_ms());
    if ($urandom_range(9) < 8) post_event(EVT_ABS, AXIS_Y, pick_raw(cal_y_lo, cal_y_hi), step_ms());
    press_at = step_ms();
    post_event(EVT_KEY, KEY_TOUCH, KEY_PRESS, press_at);
    case ($urandom_range(9))
      0: begin
        // repeated press restarts the timing
        press_at = step_ms();
        post_event(EVT_KEY, KEY_TOUCH, KEY_PRESS, press_at);
      end
      1: post_event(EVT_ABS, AXIS_X, pick_raw(cal_x_lo, cal_x_hi), press_at + 1);
      2: post_event(EVT_ABS, AXIS_Y, pick_raw(cal_y_lo, cal_y_hi), press_at + 1);
      default: ;
    endcase
    gen_ms = press_at + pick_hold();
    post_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE, gen_ms);
  endtask

  task automatic add_noise();
    case ($urandom_range(6))
      0: post_event(TYPE_W'($urandom), CODE_W'($urandom), $urandom, $urandom);
      1: post_event(EVT_KEY, KEY_TOUCH, $urandom, step_ms());
      2: post_event(EVT_ABS, CODE_W'($urandom), $urandom, step_ms());
      3: post_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE, step_ms());
      4: post_event(EVT_KEY, CODE_W'($urandom_range(0, 400)), $urandom_range(0, 1), step_ms());
      5: post_event(EVT_KEY, KEY_TOUCH, KEY_PRESS, step_ms());
      default: post_event(EVT_KEY, AXIS_X, KEY_PRESS, step_ms());
    endcase
  endtask

  task automatic gen_traffic(input int count);
    int target;
    target = events_queued + count;
    gen_ms = $urandom;
    while (events_queued < target) begin
      if ($urandom_range(99) < 65) add_tap_sequence();
      else add_noise();
    end
  endtask

  task automatic wait_idle();
    while (events_to_send.size() != 0 || in_tvalid || taps_due.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RAW_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_RAW_X_LOW:  cal_x_lo = val;
      REG_RAW_X_HIGH: cal_x_hi = val;
      REG_RAW_Y_LOW:  cal_y_lo = val;
      REG_RAW_Y_HIGH: cal_y_hi = val;
      REG_TAP_MIN:    hold_min = val[MS_CFG_W-1:0];
      REG_TAP_MAX:    hold_max = val[MS_CFG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_calibration(input raw_t xl, input raw_t xh, input raw_t yl, input raw_t yh,
                                 input logic [RAW_W-1:0] mn, input logic [RAW_W-1:0] mx);
    wait_idle();
    write_reg(REG_RAW_X_LOW, xl);
    write_reg(REG_RAW_X_HIGH, xh);
    write_reg(REG_RAW_Y_LOW, yl);
    write_reg(REG_RAW_Y_HIGH, yh);
    write_reg(REG_TAP_MIN, mn);
    write_reg(REG_TAP_MAX, mx);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  initial begin
    int lo_x;
    int lo_y;
    int mn;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settings_run = 1;

    // Directed events at reset calibration
    post_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE, 32'd1000);   // release with no press
    post_event(EVT_ABS, AXIS_X, 32'sd0, 32'd1010);
    post_event(EVT_ABS, AXIS_Y, 32'sd0, 32'd1020);
    post_event(EVT_KEY, KEY_TOUCH, KEY_PRESS, 32'd1100);
    post_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE, 32'd1150);   // exactly the minimum
    post_event(EVT_ABS, AXIS_X, 32'sd1023, 32'd1900);
    post_event(EVT_ABS, AXIS_Y, 32'sd1023, 32'd1950);
    post_event(EVT_KEY, KEY_TOUCH, KEY_PRESS, 32'd2000);
    post_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE, 32'd2999);   // one below the maximum
    post_event(EVT_ABS, AXIS_X, -32'sd5, 32'd2990);
    post_event(EVT_ABS, AXIS_Y, 32'sd2000, 32'd2995);
    post_event(EVT_KEY, KEY_TOUCH, KEY_PRESS, 32'd3000);
    post_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE, 32'd3049);   // too short
    post_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE, 32'd3100);
    post_event(EVT_KEY, KEY_TOUCH, KEY_PRESS, 32'd4000);
    post_event(EVT_KEY, KEY_TOUCH, KEY_PRESS, 32'd4500);     // retimed press
    post_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE, 32'd4550);
    post_event(EVT_KEY, KEY_TOUCH, KEY_PRESS, 32'd5000);
    post_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE, 32'd6000);   // exactly the maximum
    post_event(EVT_KEY, KEY_TOUCH, 32'sd2, 32'd6100);
    post_event(EVT_KEY, KEY_TOUCH, 32'hffff_ffff, 32'd6200);
    post_event(EVT_ABS, 16'd2, 32'sd7, 32'd6300);
    post_event(EVT_KEY, AXIS_X, KEY_PRESS, 32'd6400);
    post_event(16'hffff, 16'hffff, 32'h7fff_ffff, 32'hffff_ffff);
    post_event(EVT_ABS, AXIS_X, 32'sd512, 32'hffff_ffe0);
    post_event(EVT_KEY, KEY_TOUCH, KEY_PRESS, 32'hffff_fff0);
    post_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE, 32'h0000_0040);  // time wraps
    gen_traffic(300);

    set_calibration(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                    32'd0, 32'd65535);
    send_idle_pct = 49;
    recv_stall_pct = 0;
    gen_traffic(350);

    set_calibration(32'sd100, 32'sd100, -32'sd300, 32'sd700, 32'd1, 32'd2);
    send_idle_pct = 0;
    recv_stall_pct = 49;
    gen_traffic(350);

    // window closed: no release can make a tap
    set_calibration(-32'sd5000, 32'sd5000, 32'sd0, 32'sd4095, 32'd65535, 32'd0);
    @(posedge clk);
    write_reg(REG_UNUSED_A, $urandom);
    write_reg(REG_UNUSED_B, $urandom);
    cfg_we <= 1'b0;
    send_idle_pct = 35;
    recv_stall_pct = 35;
    gen_traffic(150);

    lo_x = $urandom_range(0, 400);
    lo_y = $urandom_range(0, 400);
    mn = $urandom_range(0, 100);
    set_calibration(lo_x, $urandom_range(3600, 4095), lo_y, $urandom_range(3600, 4095),
                    mn, mn + $urandom_range(1, 2000));
    gen_traffic(400);

    set_calibration($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 200),
                    $urandom_range(0, 65535));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    gen_traffic(320);

    wait_idle();
    $display("Sent %0d events under %0d calibration settings, %0d taps checked", events_taken,
             settings_run, taps_checked);
    $display("Included extreme/reversed/zero ranges, closed tap window, time wrap, stalls");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
src/ttcm_pkg.sv
src/ttcm_axis.sv
src/touch_tap_coordinate_mapper_unit.sv
bench/testbench.sv
